FILE: rtl/etsu_pkg.sv
// Shared types and constants for the translation-embedding score/update block.
// Holds the command codes, register indexes, word structs and the saturating energy add.
// No dependencies.
package etsu_pkg;

	localparam logic [2:0] CMD_LOAD_ENT  = 3'd0;
	localparam logic [2:0] CMD_LOAD_REL  = 3'd1;
	localparam logic [2:0] CMD_BEGIN     = 3'd2;
	localparam logic [2:0] CMD_SCORE     = 3'd3;
	localparam logic [2:0] CMD_UPDATE    = 3'd4;
	localparam logic [2:0] CMD_END       = 3'd5;

	localparam int          CFG_ADDR_BITS = 3;
	localparam logic        REG_IDX_MODE  = 1'b0;
	localparam logic        REG_IDX_RATE  = 1'b1;
	localparam logic [15:0] RATE_RESET    = 16'd66;

	localparam logic [39:0] ENERGY_MAX = 40'hFF_FFFF_FFFF;

	typedef struct packed {
		logic [2:0]         command;
		logic [9:0]         head;
		logic [9:0]         tail;
		logic [7:0]         relation;
		logic               corrupted;
		logic [9:0]         table_index;
		logic [5:0]         element_index;
		logic signed [15:0] element_value;
	} item_t;

	typedef struct packed {
		logic [39:0] energy;
		logic [2:0]  command_done;
	} result_t;

	function automatic logic [39:0] sat_add40(input logic [39:0] acc, input logic [40:0] term);
		logic [40:0] room;
		room = {1'b0, ENERGY_MAX} - term;
		if (term >= {1'b0, ENERGY_MAX} || {1'b0, acc} > room) begin
			return ENERGY_MAX;
		end
		return acc + term[39:0];
	endfunction

endpackage

FILE: rtl/etsu_ram.sv
// Generic single-write, dual-read synchronous RAM with registered read data.
// No dependencies.
module etsu_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    ra_addr,
	input  logic [AW-1:0]    rb_addr,
	output logic [WIDTH-1:0] ra_data,
	output logic [WIDTH-1:0] rb_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		ra_data <= mem[ra_addr];
		rb_data <= mem[rb_addr];
	end

endmodule

FILE: rtl/etsu_rowred.sv
// Row index reduction: head, tail and relation modulo the table row counts.
// Reciprocal multiply, then one compare and subtract. No dependencies.
module etsu_rowred #(
	parameter int ENTITY_COUNT   = 1024,
	parameter int RELATION_COUNT = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [9:0] head,
	input  logic [9:0] tail,
	input  logic [7:0] relation,
	output logic       done,
	output logic [9:0] head_row,
	output logic [9:0] tail_row,
	output logic [7:0] rel_row
);

	// quotient estimate is at most one low for indexes below 2^QS
	localparam int QS    = 20;
	localparam int E_MUL = (1 << QS) / ENTITY_COUNT;
	localparam int R_MUL = (1 << QS) / RELATION_COUNT;

	logic        run_q;
	logic        fix_q;
	logic        done_q;
	logic [9:0]  h_q, t_q;
	logic [7:0]  r_q;
	logic [9:0]  qh_q, qt_q;
	logic [7:0]  qr_q;
	logic [31:0] h_rem, t_rem, r_rem;

	assign h_rem = 32'(h_q) - 32'(qh_q) * 32'(ENTITY_COUNT);
	assign t_rem = 32'(t_q) - 32'(qt_q) * 32'(ENTITY_COUNT);
	assign r_rem = 32'(r_q) - 32'(qr_q) * 32'(RELATION_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			fix_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			run_q  <= start;
			fix_q  <= run_q;
			done_q <= fix_q;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			h_q <= head;
			t_q <= tail;
			r_q <= relation;
		end else if (fix_q) begin
			h_q <= (h_rem >= 32'(ENTITY_COUNT)) ? 10'(h_rem - 32'(ENTITY_COUNT)) : 10'(h_rem);
			t_q <= (t_rem >= 32'(ENTITY_COUNT)) ? 10'(t_rem - 32'(ENTITY_COUNT)) : 10'(t_rem);
			r_q <= (r_rem >= 32'(RELATION_COUNT)) ? 8'(r_rem - 32'(RELATION_COUNT)) :
				8'(r_rem);
		end
		if (run_q) begin
			qh_q <= 10'((32'(h_q) * 32'(E_MUL)) >> QS);
			qt_q <= 10'((32'(t_q) * 32'(E_MUL)) >> QS);
			qr_q <= 8'((32'(r_q) * 32'(R_MUL)) >> QS);
		end
	end

	assign done     = done_q;
	assign head_row = h_q;
	assign tail_row = t_q;
	assign rel_row  = r_q;

endmodule

FILE: rtl/etsu_engine.sv
// Command sequencer, element pipeline and table memories (current and next copies).
// Depends on etsu_pkg, etsu_ram, etsu_rowred.
module etsu_engine #(
	parameter int EMBED_DIM      = 64,
	parameter int ENTITY_COUNT   = 1024,
	parameter int RELATION_COUNT = 256,
	parameter int VALUE_BITS     = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  etsu_pkg::item_t  item,
	input  logic             distance_mode,
	input  logic [15:0]      learning_rate,
	output logic             busy,
	output logic             done,
	output etsu_pkg::result_t result
);

	localparam int VB   = VALUE_BITS;
	localparam int ED   = ENTITY_COUNT * EMBED_DIM;
	localparam int RD   = RELATION_COUNT * EMBED_DIM;
	localparam int EAW  = (ED > 1) ? $clog2(ED) : 1;
	localparam int RAW  = (RD > 1) ? $clog2(RD) : 1;
	localparam int MAXD = (ED > RD) ? ED : RD;
	localparam int CW   = $clog2(MAXD);
	localparam int IW   = (EMBED_DIM > 1) ? $clog2(EMBED_DIM) : 1;
	localparam int DW   = VB + 2;
	localparam int MW   = (VB + 3 > 21) ? VB + 3 : 21;
	localparam int PW   = MW + 21;
	localparam int SW   = (VB + 4 > 18) ? VB + 4 : 18;
	localparam logic signed [SW-1:0] VMAX = SW'((64'sd1 <<< (VB - 1)) - 64'sd1);
	localparam logic signed [SW-1:0] VMIN = -VMAX - SW'(1);

	typedef enum logic [2:0] {
		ST_IDLE, ST_LOAD, ST_REDUCE, ST_BASE, ST_RUN, ST_DRAIN, ST_COPY, ST_COPY_END
	} state_t;

	function automatic logic [VB-1:0] sat_v(input logic signed [SW-1:0] x);
		logic signed [SW-1:0] y;
		y = x;
		if (x > VMAX) y = VMAX;
		if (x < VMIN) y = VMIN;
		return VB'(y);
	endfunction

	state_t             state_q;
	etsu_pkg::item_t    item_q;
	etsu_pkg::result_t  result_q;
	logic               done_q;
	logic [39:0]        acc_q;
	logic [IW:0]        cnt_q;
	logic               phase_q;
	logic [CW-1:0]      cp_q;
	logic               dir_end_q;
	logic [EAW-1:0]     hb_q, tb_q;
	logic [RAW-1:0]     rb_q;

	logic               accept, is_upd, is_score, issue, pipe_busy;
	logic               rr_start, rr_done;
	logic [9:0]         h_row, t_row;
	logic [7:0]         r_row;
	logic [IW-1:0]      idx;

	// memory ports
	logic               ec_we, en_we, rc_we, rn_we;
	logic [EAW-1:0]     ec_wa, en_wa, ec_ra, ec_rb, en_ra, en_rb;
	logic [RAW-1:0]     rc_wa, rn_wa, rc_ra, rn_ra;
	logic [VB-1:0]      ec_wd, en_wd, rc_wd, rn_wd;
	logic [VB-1:0]      ec_da, ec_db, en_da, en_db, rc_da, rn_da;

	// pipeline
	logic               v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [IW-1:0]      idx_s1, idx_s2, idx_s3, idx_s4, idx_s5, idx_s6;
	logic signed [DW-1:0] d_s1, d_s2;
	logic [VB-1:0]      enh_s2, ent_s2, rnr_s2;
	logic [VB-1:0]      enh_s3, ent_s3, rnr_s3;
	logic [VB-1:0]      enh_s4, ent_s4, rnr_s4;
	logic [DW-1:0]      mag;
	logic [MW-1:0]      magm, gmag, mul_a;
	logic [20:0]        mag21, mul_b;
	logic [PW-1:0]      prod;
	logic               big, neg;
	logic [PW-1:0]      prod_s3;
	logic [DW-1:0]      mag_s3;
	logic               big_s3, neg_s3;
	logic [40:0]        term;
	logic [PW-1:0]      rnd;
	logic signed [SW-1:0] smag_s, s_s4;
	logic [VB-1:0]      rn_new, eh_new, et_new, et_base;
	logic [VB-1:0]      rn_s5, eh_s5, et_s5, et_s6;
	logic               cp_v_s1;
	logic [CW-1:0]      cp_s1;
	logic               cp_ent, cp_rel;
	logic               ld_ent, ld_rel;
	logic [31:0]        ld_addr;
	logic [VB-1:0]      ld_val;

	assign accept   = start && (state_q == ST_IDLE);
	assign is_upd   = (item_q.command == etsu_pkg::CMD_UPDATE);
	assign is_score = (item_q.command == etsu_pkg::CMD_SCORE);
	assign issue    = (state_q == ST_RUN) && (!is_upd || !phase_q);
	assign idx      = cnt_q[IW-1:0];
	assign rr_start = accept && (item.command == etsu_pkg::CMD_SCORE ||
		item.command == etsu_pkg::CMD_UPDATE);
	assign pipe_busy = v_s1 | v_s2 | v_s3 | v_s4 | v_s5 | v_s6;

	etsu_rowred #(
		.ENTITY_COUNT  (ENTITY_COUNT),
		.RELATION_COUNT(RELATION_COUNT)
	) u_rowred (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (rr_start),
		.head    (item.head),
		.tail    (item.tail),
		.relation(item.relation),
		.done    (rr_done),
		.head_row(h_row),
		.tail_row(t_row),
		.rel_row (r_row)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			done_q    <= 1'b0;
			result_q  <= '0;
			item_q    <= '0;
			acc_q     <= '0;
			cnt_q     <= '0;
			phase_q   <= 1'b0;
			cp_q      <= '0;
			dir_end_q <= 1'b0;
			hb_q      <= '0;
			tb_q      <= '0;
			rb_q      <= '0;
		end else begin
			done_q <= 1'b0;
			if (v_s3 && is_score) begin
				acc_q <= etsu_pkg::sat_add40(acc_q, term);
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						item_q <= item;
						acc_q  <= '0;
						case (item.command)
							etsu_pkg::CMD_LOAD_ENT, etsu_pkg::CMD_LOAD_REL: begin
								state_q <= ST_LOAD;
							end
							etsu_pkg::CMD_BEGIN, etsu_pkg::CMD_END: begin
								state_q   <= ST_COPY;
								cp_q      <= '0;
								dir_end_q <= (item.command == etsu_pkg::CMD_END);
							end
							etsu_pkg::CMD_SCORE, etsu_pkg::CMD_UPDATE: begin
								state_q <= ST_REDUCE;
							end
							default: begin
								done_q   <= 1'b1;
								result_q <= '{energy: '0, command_done: item.command};
							end
						endcase
					end
				end
				ST_LOAD: begin
					done_q   <= 1'b1;
					result_q <= '{energy: '0, command_done: item_q.command};
					state_q  <= ST_IDLE;
				end
				ST_REDUCE: begin
					if (rr_done) state_q <= ST_BASE;
				end
				ST_BASE: begin
					hb_q    <= EAW'(32'(h_row) * 32'(EMBED_DIM));
					tb_q    <= EAW'(32'(t_row) * 32'(EMBED_DIM));
					rb_q    <= RAW'(32'(r_row) * 32'(EMBED_DIM));
					cnt_q   <= '0;
					phase_q <= 1'b0;
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (is_upd) phase_q <= !phase_q;
					if (issue) begin
						cnt_q <= cnt_q + 1'b1;
						if (cnt_q == (IW+1)'(EMBED_DIM - 1)) state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!pipe_busy) begin
						done_q   <= 1'b1;
						result_q <= '{energy: is_score ? acc_q : 40'd0,
							command_done: item_q.command};
						state_q  <= ST_IDLE;
					end
				end
				ST_COPY: begin
					cp_q <= cp_q + 1'b1;
					if (cp_q == CW'(MAXD - 1)) state_q <= ST_COPY_END;
				end
				ST_COPY_END: begin
					done_q   <= 1'b1;
					result_q <= '{energy: '0, command_done: item_q.command};
					state_q  <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// valid bits of the element pipeline and the copy sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
			v_s4 <= 1'b0; v_s5 <= 1'b0; v_s6 <= 1'b0;
			cp_v_s1 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3 && is_upd;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			cp_v_s1 <= (state_q == ST_COPY);
		end
	end

	// s1: row data back from memory
	assign d_s1 = DW'($signed(ec_da)) - DW'($signed(ec_db)) - DW'($signed(rc_da));

	// s2: magnitude, gradient and the shared multiplier
	assign mag   = d_s2[DW-1] ? DW'(-d_s2) : DW'(d_s2);
	assign magm  = MW'(mag);
	assign big   = magm > MW'(21'h10_0000);
	assign mag21 = magm[20:0];
	assign gmag  = distance_mode ? (magm << 1) : MW'(21'h4000);
	assign neg   = distance_mode ? d_s2[DW-1] : (d_s2 <= DW'(0));
	assign mul_a = is_score ? MW'(mag21) : gmag;
	assign mul_b = is_score ? mag21 : 21'(learning_rate);
	assign prod  = PW'(mul_a) * PW'(mul_b);

	// s3: energy term, rounded step
	assign term   = !distance_mode ? 41'(mag_s3) :
		(big_s3 ? {1'b0, etsu_pkg::ENERGY_MAX} : 41'(prod_s3));
	assign rnd    = prod_s3 + PW'(17'h8000);
	assign smag_s = $signed(SW'(rnd[PW-1:16]));

	// s4: saturating updates; tail chains on head when both name the same row
	assign rn_new  = sat_v(SW'($signed(rnr_s4)) - s_s4);
	assign eh_new  = sat_v(SW'($signed(enh_s4)) - s_s4);
	assign et_base = (h_row == t_row) ? eh_new : ent_s4;
	assign et_new  = sat_v(SW'($signed(et_base)) + s_s4);

	always_ff @(posedge clk) begin
		idx_s1 <= idx;
		idx_s2 <= idx_s1;
		idx_s3 <= idx_s2;
		idx_s4 <= idx_s3;
		idx_s5 <= idx_s4;
		idx_s6 <= idx_s5;
		d_s2   <= d_s1;
		enh_s2 <= en_da;
		ent_s2 <= en_db;
		rnr_s2 <= rn_da;
		prod_s3 <= prod;
		mag_s3  <= mag;
		big_s3  <= big;
		neg_s3  <= neg;
		enh_s3  <= enh_s2;
		ent_s3  <= ent_s2;
		rnr_s3  <= rnr_s2;
		s_s4    <= (neg_s3 ^ !item_q.corrupted) ? -smag_s : smag_s;
		enh_s4  <= enh_s3;
		ent_s4  <= ent_s3;
		rnr_s4  <= rnr_s3;
		rn_s5   <= rn_new;
		eh_s5   <= eh_new;
		et_s5   <= et_new;
		et_s6   <= et_s5;
		cp_s1   <= cp_q;
	end

	// load decode
	assign ld_ent  = (state_q == ST_LOAD) && (item_q.command == etsu_pkg::CMD_LOAD_ENT) &&
		(32'(item_q.table_index) < 32'(ENTITY_COUNT)) &&
		(32'(item_q.element_index) < 32'(EMBED_DIM));
	assign ld_rel  = (state_q == ST_LOAD) && (item_q.command == etsu_pkg::CMD_LOAD_REL) &&
		(32'(item_q.table_index) < 32'(RELATION_COUNT)) &&
		(32'(item_q.element_index) < 32'(EMBED_DIM));
	assign ld_addr = 32'(item_q.table_index) * 32'(EMBED_DIM) + 32'(item_q.element_index);
	assign ld_val  = sat_v(SW'(item_q.element_value));

	assign cp_ent = cp_v_s1 && ({1'b0, cp_s1} < (CW+1)'(ED));
	assign cp_rel = cp_v_s1 && ({1'b0, cp_s1} < (CW+1)'(RD));

	// read addresses
	assign ec_ra = (state_q == ST_COPY) ? EAW'(cp_q) : tb_q + EAW'(idx);
	assign ec_rb = hb_q + EAW'(idx);
	assign en_ra = (state_q == ST_COPY) ? EAW'(cp_q) : hb_q + EAW'(idx);
	assign en_rb = tb_q + EAW'(idx);
	assign rc_ra = (state_q == ST_COPY) ? RAW'(cp_q) : rb_q + RAW'(idx);
	assign rn_ra = rc_ra;

	// write ports
	assign ec_we = ld_ent || (cp_ent && dir_end_q);
	assign ec_wa = ld_ent ? EAW'(ld_addr) : EAW'(cp_s1);
	assign ec_wd = ld_ent ? ld_val : en_da;
	assign rc_we = ld_rel || (cp_rel && dir_end_q);
	assign rc_wa = ld_rel ? RAW'(ld_addr) : RAW'(cp_s1);
	assign rc_wd = ld_rel ? ld_val : rn_da;

	always_comb begin
		en_we = 1'b0;
		en_wa = EAW'(cp_s1);
		en_wd = ec_da;
		if (cp_ent && !dir_end_q) begin
			en_we = 1'b1;
		end else if (v_s5) begin
			en_we = 1'b1;
			en_wa = hb_q + EAW'(idx_s5);
			en_wd = eh_s5;
		end else if (v_s6) begin
			en_we = 1'b1;
			en_wa = tb_q + EAW'(idx_s6);
			en_wd = et_s6;
		end
	end

	assign rn_we = (cp_rel && !dir_end_q) || v_s5;
	assign rn_wa = v_s5 ? rb_q + RAW'(idx_s5) : RAW'(cp_s1);
	assign rn_wd = v_s5 ? rn_s5 : rc_da;

	etsu_ram #(.WIDTH(VB), .DEPTH(ED)) u_ent_cur (
		.clk(clk), .we(ec_we), .waddr(ec_wa), .wdata(ec_wd),
		.ra_addr(ec_ra), .rb_addr(ec_rb), .ra_data(ec_da), .rb_data(ec_db)
	);

	etsu_ram #(.WIDTH(VB), .DEPTH(ED)) u_ent_nxt (
		.clk(clk), .we(en_we), .waddr(en_wa), .wdata(en_wd),
		.ra_addr(en_ra), .rb_addr(en_rb), .ra_data(en_da), .rb_data(en_db)
	);

	etsu_ram #(.WIDTH(VB), .DEPTH(RD)) u_rel_cur (
		.clk(clk), .we(rc_we), .waddr(rc_wa), .wdata(rc_wd),
		.ra_addr(rc_ra), .rb_addr(rc_ra), .ra_data(rc_da), .rb_data()
	);

	etsu_ram #(.WIDTH(VB), .DEPTH(RD)) u_rel_nxt (
		.clk(clk), .we(rn_we), .waddr(rn_wa), .wdata(rn_wd),
		.ra_addr(rn_ra), .rb_addr(rn_ra), .ra_data(rn_da), .rb_data()
	);

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == ST_IDLE))
		else $error("result strobe while still working");
	a_en_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(v_s5 && v_s6))
		else $error("two next-entity writes in one cycle");
	a_copy_vs_upd: assert property (@(posedge clk) disable iff (!arst_n)
		!(cp_v_s1 && (v_s5 || v_s6)))
		else $error("copy sweep overlaps element writes");
	a_issue_range: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> (cnt_q < (IW+1)'(EMBED_DIM)))
		else $error("element issued past row end");
	a_drain_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN && !pipe_busy) |=> done_q)
		else $error("drained command gave no result");
`endif

endmodule

FILE: rtl/embedding_translation_score_update.sv
// Begin copies the current tables into the next copies and end copies them back, one entry
// per cycle. An unknown command is answered with a result word without raising busy.
// One command at a time: busy stays high until its result word; a new word may start
// in the cycle the result strobe is shown. Score issues one element per cycle; update issues
// elements more slowly, limited by the single write port of the next entity table.
// Reset clears control and config registers; the tables are undefined until written.
module embedding_translation_score_update #(
	parameter int EMBED_DIM      = 64,
	parameter int ENTITY_COUNT   = 1024,
	parameter int RELATION_COUNT = 256,
	parameter int VALUE_BITS     = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  etsu_pkg::item_t                       item,
	output logic                                  busy,
	output logic                                  done,
	output etsu_pkg::result_t                     result,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [etsu_pkg::CFG_ADDR_BITS-1:0]    paddr,
	input  logic [31:0]                           pwdata,
	output logic [31:0]                           prdata,
	output logic                                  pready
);

	logic        mode_q;
	logic [15:0] rate_q;
	logic        wr;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			rate_q <= etsu_pkg::RATE_RESET;
		end else if (wr) begin
			if (paddr[2] == etsu_pkg::REG_IDX_MODE) mode_q <= pwdata[0];
			if (paddr[2] == etsu_pkg::REG_IDX_RATE) rate_q <= pwdata[15:0];
		end
	end

	assign prdata = (paddr[2] == etsu_pkg::REG_IDX_RATE) ? {16'd0, rate_q} : {31'd0, mode_q};

	etsu_engine #(
		.EMBED_DIM     (EMBED_DIM),
		.ENTITY_COUNT  (ENTITY_COUNT),
		.RELATION_COUNT(RELATION_COUNT),
		.VALUE_BITS    (VALUE_BITS)
	) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.item         (item),
		.distance_mode(mode_q),
		.learning_rate(rate_q),
		.busy         (busy),
		.done         (done),
		.result       (result)
	);

endmodule

FILE: tb/sv/embedding_translation_score_update_tb.sv
// Testbench for embedding_translation_score_update: a table of directed commands, then random
// phases under several register settings, every result checked against an in-bench model.
// Depends on etsu_pkg and the block itself.
module embedding_translation_score_update_tb;

	localparam int DIM        = 64;
	localparam int LIMIT      = 4_000_000;
	localparam int PHASE_ITEMS = 290;

	logic clk;
	logic arst_n;
	logic start;
	etsu_pkg::item_t item;
	logic busy;
	logic done;
	etsu_pkg::result_t result;
	logic psel, penable, pwrite;
	logic [etsu_pkg::CFG_ADDR_BITS-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	embedding_translation_score_update dut (
		.clk(clk), .arst_n(arst_n), .start(start), .item(item), .busy(busy), .done(done),
		.result(result), .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// model state
	int ent_cur [0:1023*DIM+DIM-1];
	int ent_nxt [0:1023*DIM+DIM-1];
	int rel_cur [0:255*DIM+DIM-1];
	int rel_nxt [0:255*DIM+DIM-1];
	logic        mdl_l2;
	logic [15:0] mdl_rate;

	etsu_pkg::result_t pending_results[$];
	int      errors;
	int      cycles;
	int      burst_left;

	// only these rows are ever read, all loaded before the first read
	int ent_rows[7] = '{0, 1, 2, 3, 4, 5, 1023};
	int rel_rows[4] = '{0, 1, 2, 255};

	typedef struct {
		etsu_pkg::item_t w;
		bit              known;
		logic [39:0]     energy;
	} row_t;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int sat16(longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return int'(v);
	endfunction

	task automatic score_update_predict(input etsu_pkg::item_t w, output etsu_pkg::result_t r);
		int h, t, rl, d, i;
		longint mag, gmag, smag, s, acc;
		bit neg;
		h = int'(w.head) * DIM;
		t = int'(w.tail) * DIM;
		rl = int'(w.relation) * DIM;
		acc = 0;
		case (w.command)
			etsu_pkg::CMD_LOAD_ENT: ent_cur[int'(w.table_index) * DIM + int'(w.element_index)] =
				int'(w.element_value);
			etsu_pkg::CMD_LOAD_REL: begin
				if (w.table_index < 256)
					rel_cur[int'(w.table_index) * DIM + int'(w.element_index)] =
						int'(w.element_value);
			end
			etsu_pkg::CMD_BEGIN: begin
				ent_nxt = ent_cur;
				rel_nxt = rel_cur;
			end
			etsu_pkg::CMD_END: begin
				ent_cur = ent_nxt;
				rel_cur = rel_nxt;
			end
			etsu_pkg::CMD_SCORE, etsu_pkg::CMD_UPDATE: begin
				for (i = 0; i < DIM; i++) begin
					d = ent_cur[t+i] - ent_cur[h+i] - rel_cur[rl+i];
					mag = d < 0 ? -d : d;
					if (w.command == etsu_pkg::CMD_SCORE) begin
						acc += mdl_l2 ? mag * mag : mag;
					end else begin
						neg = mdl_l2 ? (d < 0) : !(d > 0);
						gmag = mdl_l2 ? 2 * mag : 64'd16384;
						smag = (gmag * mdl_rate + 32768) >>> 16;
						s = neg ? -smag : smag;
						if (!w.corrupted) s = -s;
						rel_nxt[rl+i] = sat16(rel_nxt[rl+i] - s);
						ent_nxt[h+i] = sat16(ent_nxt[h+i] - s);
						ent_nxt[t+i] = sat16(ent_nxt[t+i] + s);
					end
				end
			end
			default: ;
		endcase
		// sums of at most 64 terms below 2^34 never reach the 40-bit ceiling
		r.energy = (w.command == etsu_pkg::CMD_SCORE) ? acc[39:0] : 40'd0;
		r.command_done = w.command;
	endtask

	// drive one word and hold it until the block takes it
	task automatic send(input etsu_pkg::item_t w, input bit known, input logic [39:0] kval);
		etsu_pkg::result_t r;
		score_update_predict(w, r);
		if (known) r.energy = kval;
		pending_results = {pending_results, r};
		start <= 1'b1;
		item <= w;
		@(posedge clk);
		while (busy) @(posedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(0, 40);
			start <= 1'b0;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end else begin
			burst_left--;
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] data);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == etsu_pkg::REG_IDX_MODE) mdl_l2 = data[0];
		else mdl_rate = data[15:0];
		@(posedge clk);
	endtask

	function automatic etsu_pkg::item_t mk(logic [2:0] c, int h, int t, int r, bit crp, int ti,
			int ei, int ev);
		etsu_pkg::item_t w;
		w = etsu_pkg::item_t'({$urandom, $urandom});
		w.command = c;
		w.head = 10'(h);
		w.tail = 10'(t);
		w.relation = 8'(r);
		w.corrupted = crp;
		w.table_index = 10'(ti);
		w.element_index = 6'(ei);
		w.element_value = 16'(ev);
		return w;
	endfunction

	function automatic int rand_value();
		case ($urandom_range(0, 5))
			0: return 32767;
			1: return -32768;
			2: return int'($urandom_range(0, 65535)) - 32768;
			default: return int'($urandom_range(0, 8191)) - 4096;
		endcase
	endfunction

	function automatic etsu_pkg::item_t rand_word();
		etsu_pkg::item_t w;
		int k;
		w = etsu_pkg::item_t'({$urandom, $urandom});
		w.head = 10'(ent_rows[$urandom_range(0, 6)]);
		w.tail = 10'(ent_rows[$urandom_range(0, 6)]);
		w.relation = 8'(rel_rows[$urandom_range(0, 3)]);
		w.element_value = 16'(rand_value());
		k = $urandom_range(0, 99);
		if (k < 40) w.command = etsu_pkg::CMD_SCORE;
		else if (k < 80) w.command = etsu_pkg::CMD_UPDATE;
		else if (k < 87) begin
			w.command = etsu_pkg::CMD_LOAD_ENT;
			if ($urandom_range(0, 1)) w.table_index = 10'(ent_rows[$urandom_range(0, 6)]);
		end else if (k < 94) begin
			w.command = etsu_pkg::CMD_LOAD_REL;
			if ($urandom_range(0, 1)) w.table_index = 10'(rel_rows[$urandom_range(0, 3)]);
		end else begin
			w.command = $urandom_range(0, 1) ? 3'd6 : 3'd7;
		end
		return w;
	endfunction

	// scoreboard
	always @(posedge clk) begin
		etsu_pkg::result_t exp_r;
		if (arst_n) begin
			cycles++;
			if (cycles > LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
			if (done) begin
				if (pending_results.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected word %h", result);
				end else begin
					exp_r = pending_results.pop_front();
					if (result.energy !== exp_r.energy ||
							result.command_done !== exp_r.command_done) begin
						errors++;
						if (errors <= 10)
							$display("cmd %0d: expected energy %h cmd %0d, got energy %h cmd %0d",
								exp_r.command_done, exp_r.energy, exp_r.command_done,
								result.energy, result.command_done);
					end
				end
			end
		end
	end

	initial begin
		row_t plan[15];
		int i, j, p;
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		errors = 0;
		cycles = 0;
		burst_left = 0;
		mdl_l2 = 1'b0;
		mdl_rate = etsu_pkg::RATE_RESET;
		foreach (ent_cur[k]) begin
			ent_cur[k] = 0;
			ent_nxt[k] = 0;
		end
		foreach (rel_cur[k]) begin
			rel_cur[k] = 0;
			rel_nxt[k] = 0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill every row that will be read; relation row 2 stays all zero
		foreach (ent_rows[r])
			for (j = 0; j < DIM; j++)
				send(mk(etsu_pkg::CMD_LOAD_ENT, 0, 0, 0, 0, ent_rows[r], j, rand_value()),
					1'b1, '0);
		foreach (rel_rows[r])
			for (j = 0; j < DIM; j++)
				send(mk(etsu_pkg::CMD_LOAD_REL, 0, 0, 0, 0, rel_rows[r], j,
					rel_rows[r] == 2 ? 0 : rand_value()), 1'b1, '0);

		plan[0]  = '{mk(3'd6, 1023, 1023, 255, 1, 1023, 63, -1), 1'b1, '0};
		plan[1]  = '{mk(3'd7, 0, 0, 0, 0, 0, 0, 0), 1'b1, '0};
		plan[2]  = '{mk(etsu_pkg::CMD_LOAD_REL, 0, 0, 0, 0, 1023, 5, 32767), 1'b1, '0};
		plan[3]  = '{mk(etsu_pkg::CMD_LOAD_ENT, 0, 0, 0, 0, 4, 63, 32767), 1'b1, '0};
		plan[4]  = '{mk(etsu_pkg::CMD_LOAD_ENT, 0, 0, 0, 0, 5, 0, -32768), 1'b1, '0};
		plan[5]  = '{mk(etsu_pkg::CMD_SCORE, 3, 3, 2, 0, 0, 0, 0), 1'b1, '0};
		plan[6]  = '{mk(etsu_pkg::CMD_SCORE, 0, 1023, 255, 0, 0, 0, 0), 1'b0, '0};
		plan[7]  = '{mk(etsu_pkg::CMD_SCORE, 1023, 0, 0, 1, 0, 0, 0), 1'b0, '0};
		plan[8]  = '{mk(etsu_pkg::CMD_BEGIN, 0, 0, 0, 0, 0, 0, 0), 1'b1, '0};
		plan[9]  = '{mk(etsu_pkg::CMD_UPDATE, 0, 1, 1, 0, 0, 0, 0), 1'b0, '0};
		plan[10] = '{mk(etsu_pkg::CMD_UPDATE, 2, 2, 0, 1, 0, 0, 0), 1'b0, '0};
		plan[11] = '{mk(etsu_pkg::CMD_UPDATE, 1023, 5, 255, 1, 0, 0, 0), 1'b0, '0};
		plan[12] = '{mk(etsu_pkg::CMD_SCORE, 0, 1, 1, 0, 0, 0, 0), 1'b0, '0};
		plan[13] = '{mk(etsu_pkg::CMD_END, 0, 0, 0, 0, 0, 0, 0), 1'b1, '0};
		plan[14] = '{mk(etsu_pkg::CMD_SCORE, 0, 1, 1, 0, 0, 0, 0), 1'b0, '0};
		for (i = 0; i < 15; i++) send(plan[i].w, plan[i].known, plan[i].energy);

		// random phases, each a full batch under its own register setting
		for (p = 0; p < 3; p++) begin
			drain();
			case (p)
				0: begin
					write_reg(etsu_pkg::REG_IDX_MODE, 32'd1);
					write_reg(etsu_pkg::REG_IDX_RATE, 32'd0);
				end
				1: begin
					write_reg(etsu_pkg::REG_IDX_MODE, 32'd0);
					write_reg(etsu_pkg::REG_IDX_RATE, 32'hFFFF_FFFF);
				end
				default: begin
					write_reg(etsu_pkg::REG_IDX_MODE, 32'hFFFF_FFFF);
					write_reg(etsu_pkg::REG_IDX_RATE, $urandom);
				end
			endcase
			send(mk(etsu_pkg::CMD_BEGIN, 0, 0, 0, 0, 0, 0, 0), 1'b1, '0);
			for (i = 0; i < PHASE_ITEMS; i++) begin
				send(rand_word(), 1'b0, '0);
				if (i == PHASE_ITEMS / 2) drain();
			end
			send(mk(etsu_pkg::CMD_END, 0, 0, 0, 0, 0, 0, 0), 1'b1, '0);
		end

		drain();
		repeat (200) @(posedge clk);
		errors += pending_results.size();
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
